/* src/sensor_hub_spi_transfer_sequencer_assert.svh */
// assertion macros for the transfer sequencer, evaluated on clk with rst_n low as disable
`ifndef SENSOR_HUB_SPI_TRANSFER_SEQUENCER_ASSERT_SVH
`define SENSOR_HUB_SPI_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SHSTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHSTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/shsts_pkg.sv */
`default_nettype none

package shsts_pkg;

  localparam int unsigned HEADER_LEN_DEF = 4;
  localparam int unsigned RX_MAX_DEF     = 512;
  localparam int unsigned TX_MAX_DEF     = 256;

  // top bit of the length header is a continuation flag
  localparam logic [15:0] HDR_CONT_BIT = 16'h8000;

  localparam logic [2:0] REQ_IRQ   = 3'd0;
  localparam logic [2:0] REQ_DONE  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_OPEN  = 3'd4;
  localparam logic [2:0] REQ_CLOSE = 3'd5;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_HDR   = 2'd2;
  localparam logic [1:0] OP_BODY  = 2'd3;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_OK        = 2'd1;
  localparam logic [1:0] ST_BAD_PARAM = 2'd2;
  localparam logic [1:0] ST_OPEN      = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] time_us;
    logic [7:0]  hdr_lo;
    logic [7:0]  hdr_hi;
    logic [15:0] req_len;
  } req_t;

  typedef struct packed {
    logic        cs_n;
    logic        wake_n;
    logic        reset_n;
    logic [1:0]  start_op;
    logic [9:0]  xfer_len;
    logic [1:0]  status;
    logic [9:0]  count;
    logic [31:0] stamp_us;
    logic        boot_pending;
  } rsp_t;

endpackage

`default_nettype wire

/* src/shsts_if.sv */
`default_nettype none

interface shsts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] time_us;
  logic [7:0]  hdr_lo;
  logic [7:0]  hdr_hi;
  logic [15:0] req_len;

  modport source (output valid, req_type, time_us, hdr_lo, hdr_hi, req_len, input ready);
  modport sink (input valid, req_type, time_us, hdr_lo, hdr_hi, req_len, output ready);
endinterface

interface shsts_rsp_if;
  logic        valid;
  logic        ready;
  logic        cs_n;
  logic        wake_n;
  logic        reset_n;
  logic [1:0]  start_op;
  logic [9:0]  xfer_len;
  logic [1:0]  status;
  logic [9:0]  count;
  logic [31:0] stamp_us;
  logic        boot_pending;

  modport source (
    output valid, cs_n, wake_n, reset_n, start_op, xfer_len, status, count, stamp_us,
           boot_pending,
    input  ready
  );
  modport sink (
    input  valid, cs_n, wake_n, reset_n, start_op, xfer_len, status, count, stamp_us,
           boot_pending,
    output ready
  );
endinterface

`default_nettype wire

/* src/shsts_engine.sv */
`default_nettype none

module shsts_engine #(
  parameter int unsigned HEADER_LEN = shsts_pkg::HEADER_LEN_DEF,
  parameter int unsigned RX_MAX     = shsts_pkg::RX_MAX_DEF,
  parameter int unsigned TX_MAX     = shsts_pkg::TX_MAX_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire shsts_pkg::req_t req,
  output shsts_pkg::rsp_t     rsp
);
  import shsts_pkg::*;

  localparam int unsigned RX_W = $clog2(RX_MAX + 1);
  localparam int unsigned TX_W = $clog2(TX_MAX + 1);

  typedef enum logic [2:0] {
    PH_CLOSED,
    PH_IDLE,
    PH_HDR,
    PH_BODY,
    PH_WRITE
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [RX_W-1:0]   rx_pending_r, rx_pending_nxt;
  logic [TX_W-1:0]   tx_pending_r, tx_pending_nxt;
  logic              irq_pending_r, irq_pending_nxt;
  logic              reset_flag_r, reset_flag_nxt;
  logic              opened_r, opened_nxt;
  logic [31:0]       rx_stamp_r, rx_stamp_nxt;
  logic              cs_level_r, cs_level_nxt;
  logic              wake_level_r, wake_level_nxt;
  logic              rst_level_r, rst_level_nxt;

  logic [15:0]       hdr_raw;
  logic [14:0]       hdr_len;
  logic [RX_W-1:0]   pkt_len;
  logic              try_go;
  logic [1:0]        op_start;
  logic [9:0]        op_len;
  logic [1:0]        status;
  logic [9:0]        count;
  logic [31:0]       stamp;

  // masked and capped packet length from the header bytes
  always_comb begin
    hdr_raw = {req.hdr_hi, req.hdr_lo} & ~HDR_CONT_BIT;
    hdr_len = hdr_raw[14:0];
    if (hdr_len > 15'(RX_MAX)) begin
      pkt_len = RX_W'(RX_MAX);
    end else begin
      pkt_len = RX_W'(hdr_len);
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    rx_pending_nxt  = rx_pending_r;
    tx_pending_nxt  = tx_pending_r;
    irq_pending_nxt = irq_pending_r;
    reset_flag_nxt  = reset_flag_r;
    opened_nxt      = opened_r;
    rx_stamp_nxt    = rx_stamp_r;
    cs_level_nxt    = cs_level_r;
    wake_level_nxt  = wake_level_r;
    rst_level_nxt   = rst_level_r;
    try_go          = 1'b0;
    op_start        = OP_NONE;
    op_len          = '0;
    status          = ST_NONE;
    count           = '0;
    stamp           = '0;

    case (req.req_type)
      REQ_IRQ: begin
        if (phase_r != PH_CLOSED) begin
          rx_stamp_nxt    = req.time_us;
          reset_flag_nxt  = 1'b0;
          irq_pending_nxt = 1'b1;
          try_go          = 1'b1;
        end
      end
      REQ_DONE: begin
        if (opened_r) begin
          case (phase_r)
            PH_HDR: begin
              if (32'(pkt_len) > 32'(HEADER_LEN)) begin
                phase_nxt = PH_BODY;
                op_start  = OP_BODY;
                op_len    = 10'(32'(pkt_len) - 32'(HEADER_LEN));
              end else begin
                cs_level_nxt   = 1'b1;
                rx_pending_nxt = '0;
                phase_nxt      = PH_IDLE;
                try_go         = 1'b1;
              end
            end
            PH_BODY: begin
              cs_level_nxt   = 1'b1;
              rx_pending_nxt = pkt_len;
              phase_nxt      = PH_IDLE;
              try_go         = 1'b1;
            end
            PH_WRITE: begin
              cs_level_nxt = 1'b1;
              if (32'(tx_pending_r) < 32'(pkt_len)) begin
                rx_pending_nxt = RX_W'(tx_pending_r);
              end else begin
                rx_pending_nxt = pkt_len;
              end
              tx_pending_nxt = '0;
              phase_nxt      = PH_IDLE;
              try_go         = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      REQ_WRITE: begin
        if (32'(req.req_len) > 32'(TX_MAX)) begin
          status = ST_BAD_PARAM;
        end else if (tx_pending_r == '0) begin
          tx_pending_nxt = TX_W'(req.req_len);
          status         = ST_OK;
          count          = 10'(req.req_len);
          wake_level_nxt = 1'b0;
        end
      end
      REQ_READ: begin
        if (rx_pending_r != '0) begin
          if (32'(req.req_len) >= 32'(rx_pending_r)) begin
            status = ST_OK;
            count  = 10'(rx_pending_r);
            stamp  = rx_stamp_r;
          end else begin
            status = ST_BAD_PARAM;
          end
          rx_pending_nxt = '0;
          try_go         = 1'b1;
        end
      end
      REQ_OPEN: begin
        if (opened_r) begin
          status = ST_OPEN;
        end else begin
          opened_nxt      = 1'b1;
          cs_level_nxt    = 1'b1;
          rx_pending_nxt  = '0;
          tx_pending_nxt  = '0;
          irq_pending_nxt = 1'b0;
          reset_flag_nxt  = 1'b1;
          phase_nxt       = PH_IDLE;
          wake_level_nxt  = 1'b1;
          rst_level_nxt   = 1'b1;
          status          = ST_OK;
        end
      end
      REQ_CLOSE: begin
        phase_nxt     = PH_CLOSED;
        rst_level_nxt = 1'b0;
        cs_level_nxt  = 1'b1;
        opened_nxt    = 1'b0;
      end
      default: begin
      end
    endcase

    // start the next transfer once idle, with no unread receive data and an interrupt waiting
    if (try_go && phase_nxt == PH_IDLE && rx_pending_nxt == '0 && irq_pending_nxt) begin
      irq_pending_nxt = 1'b0;
      cs_level_nxt    = 1'b0;
      if (tx_pending_nxt != '0) begin
        phase_nxt      = PH_WRITE;
        op_start       = OP_WRITE;
        op_len         = 10'(tx_pending_nxt);
        wake_level_nxt = 1'b1;
      end else begin
        phase_nxt = PH_HDR;
        op_start  = OP_HDR;
        op_len    = 10'(HEADER_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_CLOSED;
      rx_pending_r  <= '0;
      tx_pending_r  <= '0;
      irq_pending_r <= 1'b0;
      reset_flag_r  <= 1'b0;
      opened_r      <= 1'b0;
      rx_stamp_r    <= '0;
      cs_level_r    <= 1'b1;
      wake_level_r  <= 1'b1;
      rst_level_r   <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      rx_pending_r  <= rx_pending_nxt;
      tx_pending_r  <= tx_pending_nxt;
      irq_pending_r <= irq_pending_nxt;
      reset_flag_r  <= reset_flag_nxt;
      opened_r      <= opened_nxt;
      rx_stamp_r    <= rx_stamp_nxt;
      cs_level_r    <= cs_level_nxt;
      wake_level_r  <= wake_level_nxt;
      rst_level_r   <= rst_level_nxt;
    end
  end

  always_comb begin
    rsp.cs_n         = cs_level_nxt;
    rsp.wake_n       = wake_level_nxt;
    rsp.reset_n      = rst_level_nxt;
    rsp.start_op     = op_start;
    rsp.xfer_len     = op_len;
    rsp.status       = status;
    rsp.count        = count;
    rsp.stamp_us     = stamp;
    rsp.boot_pending = reset_flag_nxt;
  end

endmodule

`default_nettype wire

/* src/sensor_hub_spi_transfer_sequencer.sv */
// an accepted event waits in the input register until its result is registered at the output
// throughput: one event per cycle while the output is not stalled, set by the single-pass
// update between the input and result registers; while the result register is stalled the
// input register still takes one more event
// reset: synchronous active-low rst_n closes the link, clears both stages and pending
// lengths, and sets the chip select and wake levels high with the device reset level held low
`default_nettype none
`include "sensor_hub_spi_transfer_sequencer_assert.svh"

module sensor_hub_spi_transfer_sequencer #(
  parameter int unsigned HEADER_LEN = shsts_pkg::HEADER_LEN_DEF,
  parameter int unsigned RX_MAX     = shsts_pkg::RX_MAX_DEF,
  parameter int unsigned TX_MAX     = shsts_pkg::TX_MAX_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  shsts_req_if.sink    in_chan,
  shsts_rsp_if.source  out_chan
);
  import shsts_pkg::*;

  req_t  in_data_r;
  logic  in_vld_r;
  rsp_t  out_data_r;
  logic  out_vld_r;
  rsp_t  rsp;
  logic  adv;
  logic  in_take;

  assign adv     = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !in_vld_r || adv;

  shsts_engine #(
    .HEADER_LEN (HEADER_LEN),
    .RX_MAX     (RX_MAX),
    .TX_MAX     (TX_MAX)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .req   (in_data_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r.req_type <= in_chan.req_type;
      in_data_r.time_us  <= in_chan.time_us;
      in_data_r.hdr_lo   <= in_chan.hdr_lo;
      in_data_r.hdr_hi   <= in_chan.hdr_hi;
      in_data_r.req_len  <= in_chan.req_len;
    end
    if (adv) begin
      out_data_r <= rsp;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.cs_n         = out_data_r.cs_n;
  assign out_chan.wake_n       = out_data_r.wake_n;
  assign out_chan.reset_n      = out_data_r.reset_n;
  assign out_chan.start_op     = out_data_r.start_op;
  assign out_chan.xfer_len     = out_data_r.xfer_len;
  assign out_chan.status       = out_data_r.status;
  assign out_chan.count        = out_data_r.count;
  assign out_chan.stamp_us     = out_data_r.stamp_us;
  assign out_chan.boot_pending = out_data_r.boot_pending;

  `SHSTS_ASSERT_NXT(a_adv_fills_out, adv, out_vld_r, "advanced transaction missing at output")
  `SHSTS_ASSERT_IMP(a_no_op_no_len, out_vld_r && out_data_r.start_op == OP_NONE,
    out_data_r.xfer_len == 10'd0, "length without transfer")
  `SHSTS_ASSERT_IMP(a_fail_no_count, out_vld_r && out_data_r.status != ST_OK,
    out_data_r.count == 10'd0 && out_data_r.stamp_us == 32'd0, "count or stamp without success")
  `SHSTS_ASSERT_IMP(a_op_needs_cs, out_vld_r && out_data_r.start_op != OP_NONE,
    !out_data_r.cs_n, "transfer started with chip select released")

endmodule

`default_nettype wire
